// File: rtl/assert_macros.svh
// Assertion helpers used by the RTL. They compile to nothing when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// A condition that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
// A condition that must hold in the same cycle as its trigger.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// A condition that must hold in the cycle after its trigger.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_ALWAYS(label, clk, rst, cond, msg)
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

// File: rtl/bbu_pkg.sv
package bbu_pkg;

   // Microprogram geometry.
   localparam int STEP_W      = 5;
   localparam int UCODE_DEPTH = 21;
   localparam logic [STEP_W-1:0] BEZ_ENTRY = 5'd7;

   // Fixed-point constants.
   localparam int PHASE_ONE = 65536;
   localparam int RATE_MIN  = 33;
   localparam int WET_ONE   = 16384;
   localparam int WET_TWO   = 32768;

   // Control and status register map.
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 25;
   localparam logic [CSR_INDEX_W-1:0] CSR_RATE  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SCALE = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_STEP  = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_WET   = 2'd3;

   localparam logic [16:0] RATE_RESET  = 17'd65536;
   localparam logic [24:0] SCALE_RESET = 25'd131072;
   localparam logic [23:0] STEP_RESET  = 24'd32768;
   localparam logic [15:0] WET_RESET   = 16'd32768;

   // Multiplier operand A sources.
   typedef enum logic [3:0] {
      OPA_XQ,
      OPA_STEP,
      OPA_N,
      OPA_OLDEST,
      OPA_MIDDLE,
      OPA_NEWEST,
      OPA_CBL,
      OPA_BAL,
      OPA_BEZ,
      OPA_X
   } a_sel_type;

   // Multiplier operand B sources.
   typedef enum logic [2:0] {
      OPB_SCALE,
      OPB_STEP_ALIGN,
      OPB_STEP,
      OPB_U,
      OPB_C,
      OPB_UNITY,
      OPB_WET,
      OPB_DRY
   } b_sel_type;

   // Accumulator operations on the previous product.
   typedef enum logic [1:0] {
      ACC_HOLD,
      ACC_LOAD,
      ACC_ADD
   } acc_op_type;

   // Writeback of the accumulator into a datapath register.
   typedef enum logic [2:0] {
      WB_NONE,
      WB_N,
      WB_TAPS,
      WB_CBL,
      WB_BAL,
      WB_BEZ,
      WB_OUT
   } wb_op_type;

   // Sequencing of the step counter.
   typedef enum logic [1:0] {
      SEQ_NEXT,
      SEQ_SKIP_NOWRAP,
      SEQ_END
   } seq_op_type;

   // One control word of the microprogram.
   typedef struct packed {
      a_sel_type         a_sel;
      b_sel_type         b_sel;
      acc_op_type        acc_op;
      wb_op_type         wb_op;
      seq_op_type        seq_op;
      logic [STEP_W-1:0] target;
   } ucode_word_type;

endpackage

// File: rtl/bbu_req_if.sv
interface bbu_req_if #(parameter int SAMPLE_WIDTH = 24);
   logic                           valid;
   logic                           ready;
   logic signed [SAMPLE_WIDTH-1:0] sample_in;

   modport source (output valid, output sample_in, input ready);
   modport sink (input valid, input sample_in, output ready);
endinterface

// File: rtl/bbu_rsp_if.sv
interface bbu_rsp_if #(parameter int SAMPLE_WIDTH = 24);
   logic                           valid;
   logic                           ready;
   logic signed [SAMPLE_WIDTH-1:0] sample_out;

   modport source (output valid, output sample_out, input ready);
   modport sink (input valid, input sample_out, output ready);
endinterface

// File: rtl/bbu_ucode_rom.sv
module bbu_ucode_rom import bbu_pkg::*; (
   input  logic [STEP_W-1:0] step,
   output ucode_word_type    uword
);

   function automatic ucode_word_type uw(input a_sel_type a, input b_sel_type b,
                                         input acc_op_type ac, input wb_op_type w,
                                         input seq_op_type s);
      ucode_word_type word;
      word.a_sel  = a;
      word.b_sel  = b;
      word.acc_op = ac;
      word.wb_op  = w;
      word.seq_op = s;
      word.target = BEZ_ENTRY;
      return word;
   endfunction

   // The program. Each step issues one product, may fold the previous product into the
   // accumulator and may write the accumulator back. The quantizer steps are skipped
   // when the phase does not wrap, since the hold does not take a new sample then.
   always_comb begin
      unique case (step)
         // Quantizer: n = floor((x*scale + step term) / 2^k).
         5'd0:  uword = uw(OPA_XQ,     OPB_SCALE,      ACC_HOLD, WB_NONE, SEQ_SKIP_NOWRAP);
         5'd1:  uword = uw(OPA_STEP,   OPB_STEP_ALIGN, ACC_LOAD, WB_NONE, SEQ_NEXT);
         5'd2:  uword = uw(OPA_X,      OPB_DRY,        ACC_ADD,  WB_NONE, SEQ_NEXT);
         5'd3:  uword = uw(OPA_X,      OPB_DRY,        ACC_HOLD, WB_N,    SEQ_NEXT);
         // q = n*step, aligned and saturated, enters the hold.
         5'd4:  uword = uw(OPA_N,      OPB_STEP,       ACC_HOLD, WB_NONE, SEQ_NEXT);
         5'd5:  uword = uw(OPA_X,      OPB_DRY,        ACC_LOAD, WB_NONE, SEQ_NEXT);
         5'd6:  uword = uw(OPA_X,      OPB_DRY,        ACC_HOLD, WB_TAPS, SEQ_NEXT);
         // First Bezier level: oldest/middle and middle/newest blends.
         5'd7:  uword = uw(OPA_OLDEST, OPB_U,          ACC_HOLD, WB_NONE, SEQ_NEXT);
         5'd8:  uword = uw(OPA_MIDDLE, OPB_C,          ACC_LOAD, WB_NONE, SEQ_NEXT);
         5'd9:  uword = uw(OPA_MIDDLE, OPB_U,          ACC_ADD,  WB_NONE, SEQ_NEXT);
         5'd10: uword = uw(OPA_NEWEST, OPB_C,          ACC_LOAD, WB_CBL,  SEQ_NEXT);
         5'd11: uword = uw(OPA_X,      OPB_DRY,        ACC_ADD,  WB_NONE, SEQ_NEXT);
         // Second level, with the middle tap weighted by one.
         5'd12: uword = uw(OPA_MIDDLE, OPB_UNITY,      ACC_HOLD, WB_BAL,  SEQ_NEXT);
         5'd13: uword = uw(OPA_CBL,    OPB_U,          ACC_LOAD, WB_NONE, SEQ_NEXT);
         5'd14: uword = uw(OPA_BAL,    OPB_C,          ACC_ADD,  WB_NONE, SEQ_NEXT);
         5'd15: uword = uw(OPA_X,      OPB_DRY,        ACC_ADD,  WB_NONE, SEQ_NEXT);
         5'd16: uword = uw(OPA_X,      OPB_DRY,        ACC_HOLD, WB_BEZ,  SEQ_NEXT);
         // Wet/dry mix.
         5'd17: uword = uw(OPA_BEZ,    OPB_WET,        ACC_HOLD, WB_NONE, SEQ_NEXT);
         5'd18: uword = uw(OPA_X,      OPB_DRY,        ACC_LOAD, WB_NONE, SEQ_NEXT);
         5'd19: uword = uw(OPA_X,      OPB_DRY,        ACC_ADD,  WB_NONE, SEQ_NEXT);
         5'd20: uword = uw(OPA_X,      OPB_DRY,        ACC_HOLD, WB_OUT,  SEQ_END);
         default: uword = uw(OPA_X,    OPB_DRY,        ACC_HOLD, WB_NONE, SEQ_END);
      endcase
   end

endmodule

// File: rtl/bbu_datapath.sv
module bbu_datapath import bbu_pkg::*; #(
   parameter int SAMPLE_WIDTH = 24
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic signed [SAMPLE_WIDTH-1:0] sample_in,
   input  logic                           run,
   input  ucode_word_type                 uword,
   input  logic                           csr_we,
   input  logic [CSR_INDEX_W-1:0]         csr_index,
   input  logic [CSR_DATA_W-1:0]          csr_wdata,
   output logic                           wrap,
   output logic signed [SAMPLE_WIDTH-1:0] mix
);

   localparam int F    = SAMPLE_WIDTH - 1;
   localparam int LS   = (F < 17) ? 17 - F : 0;
   localparam int RS   = (F >= 17) ? F - 17 : 0;
   localparam int NSH  = (F >= 17) ? F + 8 : 25;
   localparam int QL   = (F >= 24) ? F - 24 : 0;
   localparam int QR   = (F < 24) ? 24 - F : 0;
   localparam int NW   = 20;
   localparam int AW   = (SAMPLE_WIDTH + 1 > 25) ? SAMPLE_WIDTH + 1 : 25;
   localparam int BW   = 26;
   localparam int PW   = AW + BW;
   localparam int ACCW = PW + 2;

   localparam logic signed [BW-1:0]   STEP_ALIGN = BW'(2 ** RS);
   localparam logic signed [BW-1:0]   UNITY      = BW'(PHASE_ONE);
   localparam logic signed [ACCW-1:0] SAT_HI     = {{(ACCW - F){1'b0}}, {F{1'b1}}};
   localparam logic signed [ACCW-1:0] SAT_LO     = {{(ACCW - F){1'b1}}, {F{1'b0}}};

   function automatic logic signed [SAMPLE_WIDTH-1:0] saturate(
      input logic signed [ACCW-1:0] v);
      logic signed [ACCW-1:0] r;
      r = v;
      if (v > SAT_HI) begin
         r = SAT_HI;
      end else if (v < SAT_LO) begin
         r = SAT_LO;
      end
      return r[SAMPLE_WIDTH-1:0];
   endfunction

   // Configuration registers.
   logic [16:0] rate_ff;
   logic [24:0] scale_ff;
   logic [23:0] qstep_ff;
   logic [15:0] wet_ff;

   // Architectural state.
   logic [17:0]                    phase_ff;
   logic [17:0]                    phase_in;
   logic                           wrap_ff;
   logic                           wrap_in;
   logic signed [SAMPLE_WIDTH-1:0] tap_newest_ff;
   logic signed [SAMPLE_WIDTH-1:0] tap_middle_ff;
   logic signed [SAMPLE_WIDTH-1:0] tap_oldest_ff;

   // Working registers.
   logic signed [SAMPLE_WIDTH-1:0] x_ff;
   logic signed [NW-1:0]           n_ff;
   logic signed [SAMPLE_WIDTH-1:0] cbl_ff;
   logic signed [SAMPLE_WIDTH-1:0] bal_ff;
   logic signed [SAMPLE_WIDTH-1:0] bez_ff;
   logic signed [PW-1:0]           prod_ff;
   logic signed [ACCW-1:0]         acc_ff;

   logic [16:0]             rate_eff;
   logic [17:0]             phase_sum;
   logic [16:0]             coef_c;
   logic [16:0]             coef_u;
   logic [14:0]             wet_gain;
   logic [14:0]             dry_gain;
   logic signed [AW-1:0]    a_op;
   logic signed [BW-1:0]    b_op;
   logic signed [ACCW-1:0]  q_aligned;

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         rate_ff  <= RATE_RESET;
         scale_ff <= SCALE_RESET;
         qstep_ff <= STEP_RESET;
         wet_ff   <= WET_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_RATE:  rate_ff  <= csr_wdata[16:0];
            CSR_SCALE: scale_ff <= csr_wdata[24:0];
            CSR_STEP:  qstep_ff <= csr_wdata[23:0];
            CSR_WET:   wet_ff   <= csr_wdata[15:0];
            default:   rate_ff  <= rate_ff;
         endcase
      end
   end

   // Phase accumulator with the rate clamped to its legal range.
   always_comb begin
      rate_eff = rate_ff;
      if (rate_ff < 17'(RATE_MIN)) begin
         rate_eff = 17'(RATE_MIN);
      end else if (rate_ff > 17'(PHASE_ONE)) begin
         rate_eff = 17'(PHASE_ONE);
      end
      phase_sum = phase_ff + {1'b0, rate_eff};
      wrap_in   = phase_sum > 18'(PHASE_ONE);
      phase_in  = wrap_in ? phase_sum - 18'(PHASE_ONE) : phase_sum;
   end

   // Blend weights and mix gains.
   always_comb begin
      coef_c   = phase_ff[16:0];
      coef_u   = 17'(PHASE_ONE) - coef_c;
      wet_gain = (wet_ff > 16'(WET_ONE)) ? 15'(WET_ONE) : wet_ff[14:0];
      if (wet_ff >= 16'(WET_TWO)) begin
         dry_gain = '0;
      end else if (wet_ff <= 16'(WET_ONE)) begin
         dry_gain = 15'(WET_ONE);
      end else begin
         dry_gain = 15'(16'(WET_TWO) - wet_ff);
      end
   end

   // Operand selection for the shared multiplier.
   always_comb begin
      unique case (uword.a_sel)
         OPA_XQ:     a_op = AW'(x_ff) <<< LS;
         OPA_STEP:   a_op = AW'({1'b0, qstep_ff});
         OPA_N:      a_op = AW'(n_ff);
         OPA_OLDEST: a_op = AW'(tap_oldest_ff);
         OPA_MIDDLE: a_op = AW'(tap_middle_ff);
         OPA_NEWEST: a_op = AW'(tap_newest_ff);
         OPA_CBL:    a_op = AW'(cbl_ff);
         OPA_BAL:    a_op = AW'(bal_ff);
         OPA_BEZ:    a_op = AW'(bez_ff);
         OPA_X:      a_op = AW'(x_ff);
         default:    a_op = '0;
      endcase
      unique case (uword.b_sel)
         OPB_SCALE:      b_op = BW'({1'b0, scale_ff});
         OPB_STEP_ALIGN: b_op = STEP_ALIGN;
         OPB_STEP:       b_op = BW'({1'b0, qstep_ff});
         OPB_U:          b_op = BW'({1'b0, coef_u});
         OPB_C:          b_op = BW'({1'b0, coef_c});
         OPB_UNITY:      b_op = UNITY;
         OPB_WET:        b_op = BW'({1'b0, wet_gain});
         OPB_DRY:        b_op = BW'({1'b0, dry_gain});
         default:        b_op = '0;
      endcase
   end

   // The product n*step moved to the sample's fraction bits, floored.
   always_comb begin
      if (F >= 24) begin
         q_aligned = acc_ff <<< QL;
      end else begin
         q_aligned = acc_ff >>> QR;
      end
   end

   // Phase and tap state.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= 18'(PHASE_ONE);
         wrap_ff       <= 1'b0;
         tap_newest_ff <= '0;
         tap_middle_ff <= '0;
         tap_oldest_ff <= '0;
      end else if (start) begin
         phase_ff <= phase_in;
         wrap_ff  <= wrap_in;
      end else if (run && uword.wb_op == WB_TAPS && wrap_ff) begin
         tap_oldest_ff <= tap_middle_ff;
         tap_middle_ff <= tap_newest_ff;
         tap_newest_ff <= saturate(q_aligned);
      end
   end

   // Multiplier, accumulator and writebacks.
   always_ff @(posedge clock) begin
      if (start) begin
         x_ff <= sample_in;
      end
      if (run) begin
         prod_ff <= a_op * b_op;
         unique case (uword.acc_op)
            ACC_LOAD: acc_ff <= ACCW'(prod_ff);
            ACC_ADD:  acc_ff <= acc_ff + ACCW'(prod_ff);
            default:  acc_ff <= acc_ff;
         endcase
         unique case (uword.wb_op)
            WB_N:    n_ff   <= acc_ff[NSH+NW-1:NSH];
            WB_CBL:  cbl_ff <= acc_ff[SAMPLE_WIDTH+15:16];
            WB_BAL:  bal_ff <= acc_ff[SAMPLE_WIDTH+15:16];
            WB_BEZ:  bez_ff <= acc_ff[SAMPLE_WIDTH+16:17];
            default: n_ff   <= n_ff;
         endcase
      end
   end

   assign wrap = wrap_ff;
   assign mix  = saturate(acc_ff >>> 14);

endmodule

// File: rtl/bitcrush_bezier_undersampler_unit.sv
// The result is registered at the last step of the microprogram, which runs the
// quantizer steps only when the hold takes a new sample. A new sample is taken only
// after the program ends, since the single shared multiplier and accumulator are
// stepped through by the microprogram.
// Reset is synchronous, active high: it restores the register defaults, phase 1.0,
// zero taps, and leaves the unit idle with no result pending.
`include "assert_macros.svh"

module bitcrush_bezier_undersampler_unit import bbu_pkg::*; #(
   parameter int SAMPLE_WIDTH = 24
) (
   input  logic                   clock,
   input  logic                   reset,
   bbu_req_if.sink                req_stream,
   bbu_rsp_if.source              rsp_stream,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   logic                           busy_ff;
   logic                           busy_in;
   logic [STEP_W-1:0]              step_ff;
   logic [STEP_W-1:0]              step_in;
   logic                           rsp_valid_ff;
   logic                           rsp_valid_in;
   logic signed [SAMPLE_WIDTH-1:0] rsp_data_ff;

   ucode_word_type                 uword;
   logic                           wrap;
   logic signed [SAMPLE_WIDTH-1:0] mix;
   logic                           start;
   logic                           stall;
   logic                           run;
   logic                           out_load;

   bbu_ucode_rom u_rom (
      .step  (step_ff),
      .uword (uword)
   );

   bbu_datapath #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .sample_in (req_stream.sample_in),
      .run       (run),
      .uword     (uword),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .wrap      (wrap),
      .mix       (mix)
   );

   // Handshake: a new sample is taken whenever the program is not running and reset
   // is low. The final step waits while the output register still holds an untaken
   // result.
   assign req_stream.ready = !busy_ff && !reset;
   assign start    = req_stream.valid && req_stream.ready;
   assign stall    = (uword.wb_op == WB_OUT) && rsp_valid_ff && !rsp_stream.ready;
   assign run      = busy_ff && !stall;
   assign out_load = run && (uword.wb_op == WB_OUT);

   // Step counter with the conditional skip and the program end.
   always_comb begin
      busy_in = busy_ff;
      step_in = step_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
      end else if (run) begin
         unique case (uword.seq_op)
            SEQ_NEXT:        step_in = step_ff + 1'b1;
            SEQ_SKIP_NOWRAP: step_in = wrap ? step_ff + 1'b1 : uword.target;
            SEQ_END: begin
               busy_in = 1'b0;
               step_in = '0;
            end
            default:         step_in = '0;
         endcase
      end
   end

   // The output register is freed by a transfer and refilled at the last step.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_stream.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_data_ff <= mix;
      end
   end

   assign rsp_stream.valid      = rsp_valid_ff;
   assign rsp_stream.sample_out = rsp_data_ff;

   `ASSERT_NEXT(a_start_enters_program, clock, reset, start, busy_ff && step_ff == '0, "program did not start at step zero")
   `ASSERT_IMPLIES(a_step_in_program, clock, reset, busy_ff, step_ff < STEP_W'(UCODE_DEPTH), "step counter left the program")
   `ASSERT_IMPLIES(a_idle_step_zero, clock, reset, !busy_ff, step_ff == '0, "idle with a nonzero step")
   `ASSERT_NEXT(a_end_delivers, clock, reset, run && uword.seq_op == SEQ_END, !busy_ff && rsp_valid_ff, "program end without a pending result")

endmodule

// File: bench/bitcrush_bezier_undersampler_unit_test.sv
`timescale 1ns / 1ps

module bitcrush_bezier_undersampler_unit_test import bbu_pkg::*;;

   localparam int SAMPLE_WIDTH     = 24;
   localparam int SETTLE_CYCLES    = 30;
   localparam int LONG_HOLD_CYCLES = 160;
   localparam int CYCLE_LIMIT      = 400000;
   localparam int RANDOM_PHASES    = 8;
   localparam int PHASE_ITEMS      = 48;

   typedef logic signed [SAMPLE_WIDTH-1:0] sample_type;

   localparam sample_type SAMPLE_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
   localparam sample_type SAMPLE_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = CSR_RATE;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   bbu_req_if #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) req_if ();
   bbu_rsp_if #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) rsp_if ();

   bitcrush_bezier_undersampler_unit #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_stream (req_if),
      .rsp_stream (rsp_if),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #6 clock = ~clock;

   // Shadow copy of the register file and of the crusher state.
   logic [16:0] rate_setting  = RATE_RESET;
   logic [24:0] scale_setting = SCALE_RESET;
   logic [23:0] step_setting  = STEP_RESET;
   logic [15:0] wet_setting   = WET_RESET;
   longint      glide_phase   = PHASE_ONE;
   longint      held_new      = 0;
   longint      held_mid      = 0;
   longint      held_old      = 0;

   // Stimulus and scoreboard storage.
   sample_type samples_to_send[$];
   sample_type predicted_samples[$];

   int  items_queued     = 0;
   int  results_seen     = 0;
   int  error_count      = 0;
   int  settings_written = 0;
   int  cycle_count      = 0;
   int  send_gap         = 0;
   int  rsp_gap          = 0;
   int  rsp_hold_left    = 0;
   int  holds_done       = 0;
   bit  req_taken        = 1'b0;
   bit  hold_rsp_request = 1'b0;
   bit  steady_traffic   = 1'b0;

   // Saturate to the signed sample range.
   function automatic longint clip_to_sample(input longint v);
      longint hi;
      longint lo;
      hi = SAMPLE_MAX;
      lo = SAMPLE_MIN;
      if (v > hi) return hi;
      if (v < lo) return lo;
      return v;
   endfunction

   // Quantize one sample, advance the phase, and evaluate the Bezier mix.
   function automatic sample_type crush_and_glide(input sample_type x_in);
      longint x, prod, n, q, rate, c, u, cbl, bal, bez, wet, dry, mix;
      x = x_in;
      prod = x * longint'(scale_setting);
      n = (prod + (longint'(step_setting) <<< 6)) >>> 31;
      q = (n * longint'(step_setting)) >>> 1;
      q = clip_to_sample(q);

      rate = rate_setting;
      if (rate < RATE_MIN) rate = RATE_MIN;
      if (rate > PHASE_ONE) rate = PHASE_ONE;

      // A wrap of the phase shifts the crushed sample into the hold.
      glide_phase = glide_phase + rate;
      if (glide_phase > PHASE_ONE) begin
         glide_phase = glide_phase - PHASE_ONE;
         held_old = held_mid;
         held_mid = held_new;
         held_new = q;
      end

      c = glide_phase;
      u = PHASE_ONE - c;
      cbl = (held_old * u + held_mid * c) >>> 16;
      bal = (held_mid * u + held_new * c) >>> 16;
      bez = (held_mid * PHASE_ONE + cbl * u + bal * c) >>> 17;

      wet = wet_setting;
      if (wet > WET_ONE) wet = WET_ONE;
      dry = (wet_setting >= WET_TWO) ? 0 : WET_TWO - longint'(wet_setting);
      if (dry > WET_ONE) dry = WET_ONE;

      mix = clip_to_sample((wet * bez + dry * x) >>> 14);
      return mix[SAMPLE_WIDTH-1:0];
   endfunction

   task automatic report_mismatch(input string what, input sample_type got,
                                  input sample_type want);
      $display("MISMATCH on result %0d: %s, got %0d, expected %0d",
               results_seen, what, got, want);
      error_count++;
   endtask

   // One register write; the shadow copy follows at once since the unit is idle.
   task automatic write_setting(input logic [CSR_INDEX_W-1:0] index,
                                input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      case (index)
         CSR_RATE:  rate_setting  = value[16:0];
         CSR_SCALE: scale_setting = value[24:0];
         CSR_STEP:  step_setting  = value[23:0];
         CSR_WET:   wet_setting   = value[15:0];
         default: ;
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic apply_settings(input logic [16:0] rate, input logic [24:0] scale,
                                 input logic [23:0] step, input logic [15:0] wet);
      write_setting(CSR_RATE, CSR_DATA_W'(rate));
      write_setting(CSR_SCALE, CSR_DATA_W'(scale));
      write_setting(CSR_STEP, CSR_DATA_W'(step));
      write_setting(CSR_WET, CSR_DATA_W'(wet));
      settings_written++;
   endtask

   // Hold the sender until every result is back, then let the unit settle.
   task automatic wait_until_drained();
      while (results_seen < items_queued) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic queue_sample(input sample_type s);
      samples_to_send.push_back(s);
      items_queued++;
   endtask

   // Input driver: holds an offered sample until its transfer, with random gaps.
   always @(negedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
      end else if (req_if.valid && !req_taken) begin
         // Still waiting for the transfer.
      end else if (send_gap > 0) begin
         req_if.valid <= 1'b0;
         send_gap--;
      end else if (samples_to_send.size() == 0) begin
         req_if.valid <= 1'b0;
      end else if (!steady_traffic && $urandom_range(0, 5) == 0) begin
         req_if.valid <= 1'b0;
         send_gap = $urandom_range(0, 7);
      end else begin
         req_if.valid     <= 1'b1;
         req_if.sample_in <= samples_to_send.pop_front();
      end
   end

   // Result receiver: random stalls plus one long hold-off on request.
   always @(negedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else if (rsp_hold_left > 0) begin
         rsp_if.ready <= 1'b0;
         rsp_hold_left--;
      end else if (hold_rsp_request) begin
         rsp_if.ready <= 1'b0;
         hold_rsp_request = 1'b0;
         rsp_hold_left = LONG_HOLD_CYCLES - 1;
         holds_done++;
      end else if (rsp_gap > 0) begin
         rsp_if.ready <= 1'b0;
         rsp_gap--;
      end else if (!steady_traffic && $urandom_range(0, 4) == 0) begin
         rsp_if.ready <= 1'b0;
         rsp_gap = $urandom_range(0, 7);
      end else begin
         rsp_if.ready <= 1'b1;
      end
   end

   // Monitor: predict on each input transfer, compare on each result transfer.
   always @(posedge clock) begin
      sample_type want;
      if (!reset) begin
         req_taken <= req_if.valid && req_if.ready;
         if (req_if.valid && req_if.ready)
            predicted_samples.push_back(crush_and_glide(req_if.sample_in));
         if (rsp_if.valid && rsp_if.ready) begin
            results_seen++;
            if (predicted_samples.size() == 0) begin
               report_mismatch("result with none expected", rsp_if.sample_out, '0);
            end else begin
               want = predicted_samples.pop_front();
               if (rsp_if.sample_out !== want)
                  report_mismatch("sample_out", rsp_if.sample_out, want);
            end
         end
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Run stopped after %0d cycles with %0d of %0d results",
                  cycle_count, results_seen, items_queued);
         $display("Verification failed");
         $finish;
      end
   end

   // Sequence of phases: directed corners first, then random settings.
   initial begin
      logic [16:0] rate;
      logic [24:0] scale;
      logic [23:0] step;
      logic [15:0] wet;
      sample_type  s;
      int          k;

      req_if.valid     = 1'b0;
      req_if.sample_in = '0;
      rsp_if.ready     = 1'b0;

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset settings: full-rate phase, so every sample enters the hold.
      @(posedge clock);
      queue_sample('0);
      queue_sample(SAMPLE_MAX);
      queue_sample(SAMPLE_MIN);
      queue_sample(sample_type'(-1));
      queue_sample(sample_type'(1));
      queue_sample(24'h555555);
      queue_sample(24'hAAAAAA);
      wait_until_drained();

      // Rate above the top is clamped, wet above two, quantized value saturates.
      apply_settings(17'h1FFFF, 25'd16777216, 24'd8388608, 16'hFFFF);
      @(posedge clock);
      queue_sample(SAMPLE_MAX);
      queue_sample(SAMPLE_MIN);
      queue_sample('0);
      queue_sample(24'sd4194304);
      wait_until_drained();

      // Rate below the minimum, zero scale and step, fully dry mix.
      apply_settings(17'd0, 25'd0, 24'd0, 16'd0);
      @(posedge clock);
      queue_sample(SAMPLE_MAX);
      queue_sample(SAMPLE_MIN);
      queue_sample(24'sd12345);
      wait_until_drained();

      // Slowest legal rate, coarsest grid, equal mix.
      apply_settings(17'd33, 25'd512, 24'd256, 16'd16384);
      @(posedge clock);
      queue_sample(SAMPLE_MAX);
      queue_sample(SAMPLE_MIN);
      queue_sample(24'sd777);
      wait_until_drained();

      // All-ones scale and step, wet exactly two.
      apply_settings(17'd65536, 25'h1FFFFFF, 24'hFFFFFF, 16'd32768);
      @(posedge clock);
      queue_sample(SAMPLE_MAX);
      queue_sample(SAMPLE_MIN);
      queue_sample(-24'sd4194304);
      wait_until_drained();

      // Random phases; each ends with the sender paused until all results are in.
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case ($urandom_range(0, 9))
            0: rate = 17'd33;
            1: rate = 17'd65536;
            2: rate = 17'($urandom_range(0, 32));
            3: rate = 17'($urandom_range(65537, 131071));
            4, 5, 6: rate = 17'($urandom_range(8192, 65536));
            default: rate = 17'($urandom_range(33, 65536));
         endcase
         if ($urandom_range(0, 4) == 0) begin
            scale = 25'($urandom_range(0, 33554431));
            step  = 24'($urandom_range(0, 16777215));
         end else begin
            k     = $urandom_range(1, 16);
            scale = 25'd1 << (k + 8);
            step  = 24'd1 << (24 - k);
         end
         case ($urandom_range(0, 5))
            0: wet = 16'd0;
            1: wet = 16'd32768;
            2: wet = 16'($urandom_range(32769, 65535));
            default: wet = 16'($urandom_range(0, 32768));
         endcase
         apply_settings(rate, scale, step, wet);

         @(posedge clock);
         if (phase == RANDOM_PHASES - 1)
            steady_traffic = 1'b1;
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            case ($urandom_range(0, 9))
               0: s = $urandom_range(0, 1) ? SAMPLE_MAX : SAMPLE_MIN;
               1: s = $urandom_range(0, 1) ? sample_type'(0) : sample_type'(-1);
               2: s = sample_type'(int'($urandom_range(0, 511)) - 256);
               default: s = sample_type'($urandom);
            endcase
            queue_sample(s);
         end
         // Stall the output long enough to back the unit up into its input.
         if (phase == 2)
            hold_rsp_request = 1'b1;
         wait_until_drained();
      end

      if (predicted_samples.size() != 0) begin
         $display("%0d predicted results never arrived", predicted_samples.size());
         error_count++;
      end

      $display("Sent %0d samples under %0d register settings, covering clamped rates,",
               items_queued, settings_written + 1);
      $display("zero and full-scale grids, wet above two and %0d long output hold-off(s).",
               holds_done);
      if (error_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("%0d mismatches in %0d results", error_count, results_seen);
         $display("Verification failed");
      end
      $finish;
   end

endmodule
